// ===== rtl/core/hpenc_pkg.sv =====
// Shared types, constants and helper functions for the HPACK integer and
// status encoder. No dependencies; used by every file of the block.
package hpenc_pkg;

    // Input item field widths
    localparam int MASK_W   = 8;
    localparam int PBITS_W  = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 16;
    localparam int BYTE_W   = 8;

    // Packed stream layout (lowest bit first)
    localparam int IN_DATA_W = 64;
    localparam int MASK_LSB   = 0;
    localparam int PBITS_LSB  = MASK_LSB + MASK_W;
    localparam int VALUE_LSB  = PBITS_LSB + PBITS_W;
    localparam int STATUS_LSB = VALUE_LSB + VALUE_W;

    // Command codes
    localparam logic CMD_INTEGER = 1'b0;
    localparam logic CMD_STATUS  = 1'b1;

    // Prefix width limits
    localparam logic [PBITS_W-1:0] PBITS_MIN = 4'd1;
    localparam logic [PBITS_W-1:0] PBITS_MAX = 4'd8;

    // Byte constants
    localparam logic [BYTE_W-1:0] INDEXED_FLAG  = 8'h80;
    localparam logic [BYTE_W-1:0] STATUS_NAME   = 8'h08;
    localparam logic [BYTE_W-1:0] DIGIT_BASE    = 8'h30;
    localparam logic [STATUS_W-1:0] STATUS_MAX  = 16'd999;
    localparam logic [3:0] IDX_500              = 4'd14;

    // Byte source picked by the controller
    typedef enum logic [1:0] {
        SEL_FIRST,
        SEL_CONT,
        SEL_LEN,
        SEL_DIG
    } t_sel;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_CONT,
        S_LEN,
        S_DIG
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic emit;
        t_sel sel;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic first_last;
        logic is_int;
        logic cont_last;
        logic dig_last;
    } t_dp_stat;

    // Static table index of a known :status code, 500's above 999, else zero
    function automatic logic [3:0] f_status_index(input logic [STATUS_W-1:0] code);
        logic [3:0] idx;
        begin
            unique case (code)
                16'd200: idx = 4'd8;
                16'd204: idx = 4'd9;
                16'd206: idx = 4'd10;
                16'd304: idx = 4'd11;
                16'd400: idx = 4'd12;
                16'd404: idx = 4'd13;
                16'd500: idx = IDX_500;
                default: idx = 4'd0;
            endcase
            if (code > STATUS_MAX) idx = IDX_500;
            f_status_index = idx;
        end
    endfunction

    // Quotient by a small constant step, for v < 10*step (independent compares)
    function automatic logic [3:0] f_digit(input logic [9:0] v, input logic [9:0] step);
        logic [3:0] q;
        logic [13:0] lim;
        begin
            q = 4'd0;
            for (int k = 1; k < 10; k++) begin
                lim = 14'(k) * {4'd0, step};
                if ({4'd0, v} >= lim) q = 4'(k);
            end
            f_digit = q;
        end
    endfunction

endpackage

// ===== rtl/core/hpenc_ctrl.sv =====
// Controller of the HPACK encoder: input/output handshake and byte sequencing.
// Depends on hpenc_pkg; drives hpenc_dp through t_dp_cmd.
module hpenc_ctrl import hpenc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   slot_free;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Output slot can take a byte when empty or being drained this cycle
    assign slot_free = !r_ovalid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        o_cmd.sel  = SEL_FIRST;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FIRST;
                end
            end
            S_FIRST: begin
                o_cmd.sel = SEL_FIRST;
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    priority if (i_stat.first_last) n_state = S_IDLE;
                    else if (i_stat.is_int)         n_state = S_CONT;
                    else                            n_state = S_LEN;
                end
            end
            S_CONT: begin
                o_cmd.sel = SEL_CONT;
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.cont_last) n_state = S_IDLE;
                end
            end
            S_LEN: begin
                o_cmd.sel = SEL_LEN;
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_DIG;
                end
            end
            S_DIG: begin
                o_cmd.sel = SEL_DIG;
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.dig_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_ovalid    = o_cmd.emit || (r_ovalid && !i_out_ready);
    assign o_out_valid = r_ovalid;

endmodule

// ===== rtl/core/hpenc_dp.sv =====
// Datapath of the HPACK encoder: operand capture, first byte, 7-bit
// continuation shifter, status digits and the output byte register.
// Depends on hpenc_pkg; controlled by hpenc_ctrl.
module hpenc_dp import hpenc_pkg::*; (
    input  logic                 i_clk,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_cmd_bit,
    input  logic [MASK_W-1:0]    i_first_byte_mask,
    input  logic [PBITS_W-1:0]   i_prefix_bits,
    input  logic [VALUE_W-1:0]   i_int_value,
    input  logic [STATUS_W-1:0]  i_status_code,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_last
);

    logic               r_is_int;
    logic [BYTE_W-1:0]  r_first;
    logic               r_first_last;
    logic [VALUE_W-1:0] r_val;
    logic [1:0]         r_len;
    logic [1:0]         r_dcnt;
    logic [3:0]         r_digs [3];
    logic [BYTE_W-1:0]  r_obyte;
    logic               r_olast;

    logic [PBITS_W-1:0] pb;
    logic [BYTE_W-1:0]  pmax;
    logic               fits_prefix;
    logic [3:0]         idx;
    logic [9:0]         code10;
    logic [3:0]         d_h, d_t, d_o;
    logic [9:0]         rem_h, rem_t;
    logic [1:0]         len;
    logic [BYTE_W-1:0]  ld_first;
    logic               ld_first_last;
    logic [BYTE_W-1:0]  sel_byte;
    logic               sel_last;

    // Prefix width clamp and prefix maximum
    always_comb begin
        priority if (i_prefix_bits < PBITS_MIN) pb = PBITS_MIN;
        else if (i_prefix_bits > PBITS_MAX)     pb = PBITS_MAX;
        else                                    pb = i_prefix_bits;
    end
    assign pmax        = 8'((9'd1 << pb) - 9'd1);
    assign fits_prefix = i_int_value < {24'd0, pmax};

    // Status: table index, or up to three decimal digits of a code below 1000
    assign idx    = f_status_index(i_status_code);
    assign code10 = i_status_code[9:0];
    assign d_h    = f_digit(code10, 10'd100);
    assign rem_h  = code10 - 10'(d_h) * 10'd100;
    assign d_t    = f_digit(rem_h, 10'd10);
    assign rem_t  = rem_h - 10'(d_t) * 10'd10;
    assign d_o    = rem_t[3:0];

    always_comb begin
        priority if (code10 >= 10'd100) len = 2'd3;
        else if (code10 >= 10'd10)      len = 2'd2;
        else                            len = 2'd1;
    end

    // First byte of the run
    always_comb begin
        priority if (i_cmd_bit == CMD_INTEGER) begin
            ld_first      = fits_prefix ? (i_first_byte_mask | i_int_value[7:0])
                                        : (i_first_byte_mask | pmax);
            ld_first_last = fits_prefix;
        end else if (idx != 4'd0) begin
            ld_first      = INDEXED_FLAG | {4'd0, idx};
            ld_first_last = 1'b1;
        end else begin
            ld_first      = STATUS_NAME;
            ld_first_last = 1'b0;
        end
    end

    // Byte selected by the controller
    always_comb begin
        unique case (i_cmd.sel)
            SEL_FIRST: begin
                sel_byte = r_first;
                sel_last = r_first_last;
            end
            SEL_CONT: begin
                sel_byte = {~o_stat.cont_last, r_val[6:0]};
                sel_last = o_stat.cont_last;
            end
            SEL_LEN: begin
                sel_byte = {6'd0, r_len};
                sel_last = 1'b0;
            end
            SEL_DIG: begin
                sel_byte = DIGIT_BASE | {4'd0, r_digs[0]};
                sel_last = o_stat.dig_last;
            end
            default: begin
                sel_byte = r_first;
                sel_last = r_first_last;
            end
        endcase
    end

    // Operand capture, shifters and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_int     <= (i_cmd_bit == CMD_INTEGER);
            r_first      <= ld_first;
            r_first_last <= ld_first_last;
            r_val        <= i_int_value - {24'd0, pmax};
            r_len        <= len;
            r_dcnt       <= len;
            unique case (len)
                2'd3: begin
                    r_digs[0] <= d_h;
                    r_digs[1] <= d_t;
                    r_digs[2] <= d_o;
                end
                2'd2: begin
                    r_digs[0] <= d_t;
                    r_digs[1] <= d_o;
                    r_digs[2] <= d_o;
                end
                default: begin
                    r_digs[0] <= d_o;
                    r_digs[1] <= d_o;
                    r_digs[2] <= d_o;
                end
            endcase
        end else if (i_cmd.emit) begin
            r_obyte <= sel_byte;
            r_olast <= sel_last;
            if (i_cmd.sel == SEL_CONT) r_val <= r_val >> 7;
            if (i_cmd.sel == SEL_DIG) begin
                r_digs[0] <= r_digs[1];
                r_digs[1] <= r_digs[2];
                r_dcnt    <= r_dcnt - 2'd1;
            end
        end
    end

    assign o_stat.first_last = r_first_last;
    assign o_stat.is_int     = r_is_int;
    assign o_stat.cont_last  = (r_val[VALUE_W-1:7] == '0);
    assign o_stat.dig_last   = (r_dcnt == 2'd1);

    assign o_out_byte = r_obyte;
    assign o_last     = r_olast;

endmodule

// ===== rtl/core/hpack_integer_and_status_encoder_top.sv =====
// HPACK prefix-integer and :status encoder. Each input beat is one command and
// yields a run of 1 to 6 output bytes, one per beat, the final one with tlast.
// After acceptance the operands are captured, then the bytes go one per cycle
// into the output register while the output slot is free; the output register
// paces the run, and the next command is taken as soon as the last byte of a
// run is registered, even if that byte still waits at the output. Depends on
// hpenc_pkg, hpenc_ctrl and hpenc_dp.
module hpack_integer_and_status_encoder_top import hpenc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] first_byte_mask, [11:8] prefix_bits, [43:12] int_value,
    // [59:44] status_code, [63:60] zero
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] out_byte
    output logic [BYTE_W-1:0]    m_axis_tdata,
    output logic                 m_axis_tlast
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    hpenc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    hpenc_dp u_dp (
        .i_clk             (i_clk),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_cmd_bit         (s_axis_tuser),
        .i_first_byte_mask (s_axis_tdata[MASK_LSB +: MASK_W]),
        .i_prefix_bits     (s_axis_tdata[PBITS_LSB +: PBITS_W]),
        .i_int_value       (s_axis_tdata[VALUE_LSB +: VALUE_W]),
        .i_status_code     (s_axis_tdata[STATUS_LSB +: STATUS_W]),
        .o_out_byte        (m_axis_tdata),
        .o_last            (m_axis_tlast)
    );

endmodule

// ===== rtl/core/hpenc_chk.sv =====
// Port-level checks for the HPACK encoder top level, bound to it below.
// Depends on hpenc_pkg for widths.
module hpenc_chk import hpenc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [BYTE_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast
);

    // Stalled output beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // Stalled output beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // One command at a time: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a run is in progress");

    // When ready for a new command, any waiting byte closes the previous run
    a_idle_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
        else $error("ready for a new command in the middle of a run");

endmodule

bind hpack_integer_and_status_encoder_top hpenc_chk u_hpenc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
